// ===== design/pfe_pkg.sv =====
// ----------------------------------------------------------------------------
// pfe_pkg
// Shared types, constants and square-geometry helpers for the Playfair
// encryptor.
// ----------------------------------------------------------------------------
package pfe_pkg;

  localparam int unsigned LETTERS = 26;
  localparam int unsigned CELLS   = 25;
  localparam int unsigned SIDE    = 5;

  localparam logic [4:0] CODE_I    = 5'd8;
  localparam logic [4:0] CODE_J    = 5'd9;
  localparam logic [4:0] CODE_X    = 5'd23;
  localparam logic [4:0] CODE_LAST = 5'(LETTERS - 1);
  localparam logic [4:0] CELL_MAX  = 5'(CELLS);
  localparam logic [2:0] SIDE_LAST = 3'(SIDE - 1);

  typedef enum logic [1:0] {
    OP_KEY    = 2'd0,
    OP_FINISH = 2'd1,
    OP_PLAIN  = 2'd2,
    OP_END    = 2'd3
  } op_t;

  typedef struct packed {
    logic place_key;
    logic fill_start;
    logic fill_step;
    logic set_pending;
    logic load_pair;
    logic pair_b_x;
    logic clear_pending;
    logic read_pos;
    logic read_cell;
    logic out_first;
    logic out_second;
  } cmd_t;

  typedef struct packed {
    logic letter_ok;
    logic pend_valid;
    logic pend_match;
    logic fill_done;
    logic out_free;
  } status_t;

  function automatic logic [2:0] pos_row(input logic [4:0] pos);
    logic [2:0] row;
    if (pos >= 5'd20) begin
      row = 3'd4;
    end else if (pos >= 5'd15) begin
      row = 3'd3;
    end else if (pos >= 5'd10) begin
      row = 3'd2;
    end else if (pos >= 5'd5) begin
      row = 3'd1;
    end else begin
      row = 3'd0;
    end
    return row;
  endfunction

  function automatic logic [4:0] row_base(input logic [2:0] row);
    logic [4:0] r;
    r = {2'b00, row};
    return 5'((r << 2) + r);
  endfunction

  function automatic logic [2:0] pos_col(input logic [4:0] pos);
    logic [4:0] diff;
    diff = pos - row_base(pos_row(pos));
    return diff[2:0];
  endfunction

  function automatic logic [2:0] wrap_inc(input logic [2:0] v);
    logic [2:0] r;
    if (v >= SIDE_LAST) begin
      r = 3'd0;
    end else begin
      r = v + 3'd1;
    end
    return r;
  endfunction

  function automatic logic [4:0] cell_index(input logic [2:0] row, input logic [2:0] col);
    return 5'(row_base(row) + {2'b00, col});
  endfunction

endpackage

// ===== design/pfe_ctrl.sv =====
// ----------------------------------------------------------------------------
// pfe_ctrl
// Sequencer for the Playfair encryptor: decodes each item, walks the key
// fill and steps a pair through position lookup, cell lookup and output.
// ----------------------------------------------------------------------------
module pfe_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       opcode,
  input  pfe_pkg::status_t status,
  output pfe_pkg::cmd_t    cmd
);
  import pfe_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FILL,
    S_POS,
    S_CELL,
    S_EMIT_A,
    S_EMIT_B
  } state_t;

  state_t state;
  state_t state_next;
  op_t    op;
  logic   accept;

  assign op       = op_t'(opcode);
  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (op)
            OP_KEY: begin
              cmd.place_key = status.letter_ok;
            end
            OP_FINISH: begin
              cmd.fill_start = 1'b1;
              state_next     = S_FILL;
            end
            OP_PLAIN: begin
              if (status.letter_ok) begin
                if (!status.pend_valid) begin
                  cmd.set_pending = 1'b1;
                end else begin
                  cmd.load_pair     = 1'b1;
                  cmd.pair_b_x      = status.pend_match;
                  cmd.clear_pending = !status.pend_match;
                  state_next        = S_POS;
                end
              end
            end
            OP_END: begin
              if (status.pend_valid) begin
                cmd.load_pair     = 1'b1;
                cmd.pair_b_x      = 1'b1;
                cmd.clear_pending = 1'b1;
                state_next        = S_POS;
              end
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end
      S_FILL: begin
        cmd.fill_step = 1'b1;
        if (status.fill_done) begin
          state_next = S_IDLE;
        end
      end
      S_POS: begin
        cmd.read_pos = 1'b1;
        state_next   = S_CELL;
      end
      S_CELL: begin
        cmd.read_cell = 1'b1;
        state_next    = S_EMIT_A;
      end
      S_EMIT_A: begin
        if (status.out_free) begin
          cmd.out_first = 1'b1;
          state_next    = S_EMIT_B;
        end
      end
      S_EMIT_B: begin
        if (status.out_free) begin
          cmd.out_second = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== design/pfe_datapath.sv =====
// ----------------------------------------------------------------------------
// pfe_datapath
// Key square and letter position memories, pairing registers, square
// geometry and the output register of the Playfair encryptor.
// ----------------------------------------------------------------------------
module pfe_datapath (
  input  logic              clk,
  input  logic              rst,
  input  logic [4:0]        letter,
  input  pfe_pkg::cmd_t     cmd,
  output pfe_pkg::status_t  status,
  input  logic              out_stall,
  output logic              out_valid,
  output logic [4:0]        cipher_letter,
  output logic              last_of_pair
);
  import pfe_pkg::*;

  logic [4:0]         key_square [CELLS];
  logic [4:0]         letter_position [LETTERS];
  logic [LETTERS-1:0] letter_used;
  logic [4:0]         fill_count;
  logic [4:0]         fill_idx;
  logic [4:0]         pending_letter;
  logic               pending_valid;
  logic [4:0]         pair_a;
  logic [4:0]         pair_b;
  logic [4:0]         pos_a;
  logic [4:0]         pos_b;
  logic [4:0]         enc_a;
  logic [4:0]         enc_b;

  logic [4:0] folded;
  logic [4:0] place_code;
  logic       place_req;
  logic       place_do;
  logic [2:0] ra, ca, rb, cb;
  logic [4:0] idx_a, idx_b;
  logic       out_free;

  assign folded   = (letter == CODE_J) ? CODE_I : letter;
  assign out_free = !out_valid || !out_stall;

  assign status.letter_ok  = (folded <= CODE_LAST);
  assign status.pend_valid = pending_valid;
  assign status.pend_match = (pending_letter == folded);
  assign status.fill_done  = (fill_idx == CODE_LAST) || (fill_count == CELL_MAX);
  assign status.out_free   = out_free;

  assign place_code = cmd.fill_step ? fill_idx : folded;
  assign place_req  = cmd.place_key || (cmd.fill_step && (fill_idx != CODE_J));
  assign place_do   = place_req && (fill_count < CELL_MAX) && !letter_used[place_code];

  assign ra = pos_row(pos_a);
  assign ca = pos_col(pos_a);
  assign rb = pos_row(pos_b);
  assign cb = pos_col(pos_b);

  always_comb begin
    if (ra == rb) begin
      idx_a = cell_index(ra, wrap_inc(ca));
      idx_b = cell_index(rb, wrap_inc(cb));
    end else if (ca == cb) begin
      idx_a = cell_index(wrap_inc(ra), ca);
      idx_b = cell_index(wrap_inc(rb), cb);
    end else begin
      idx_a = cell_index(ra, cb);
      idx_b = cell_index(rb, ca);
    end
  end

  always_ff @(posedge clk) begin
    if (place_do) begin
      key_square[fill_count]      <= place_code;
      letter_position[place_code] <= fill_count;
    end
    if (cmd.read_pos) begin
      pos_a <= letter_position[pair_a];
      pos_b <= letter_position[pair_b];
    end
    if (cmd.read_cell) begin
      enc_a <= key_square[idx_a];
      enc_b <= key_square[idx_b];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_pair) begin
      pair_a <= pending_letter;
      pair_b <= cmd.pair_b_x ? CODE_X : folded;
    end
    if (cmd.out_first) begin
      cipher_letter <= enc_a;
      last_of_pair  <= 1'b0;
    end else if (cmd.out_second) begin
      cipher_letter <= enc_b;
      last_of_pair  <= 1'b1;
    end
    if (cmd.fill_start) begin
      fill_idx <= '0;
    end else if (cmd.fill_step) begin
      fill_idx <= fill_idx + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      letter_used    <= '0;
      fill_count     <= '0;
      pending_letter <= '0;
      pending_valid  <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (place_do) begin
        letter_used[place_code] <= 1'b1;
        fill_count              <= fill_count + 5'd1;
      end
      if (cmd.set_pending) begin
        pending_letter <= folded;
        pending_valid  <= 1'b1;
      end else if (cmd.clear_pending) begin
        pending_valid <= 1'b0;
      end
      if (cmd.out_first || cmd.out_second) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== design/playfair_cipher_encryptor.sv =====
// ----------------------------------------------------------------------------
// playfair_cipher_encryptor
// Playfair encryptor with a 5x5 key square built from key letter items.
// ----------------------------------------------------------------------------
// A key letter item and a plaintext letter item that only opens a pair are
// both handled in the cycle they are accepted. A finish item walks the fill
// over the letter codes in order, skipping J, and stops early once the square
// holds 25 letters. An item that completes a pair is accepted and then passes
// through a registered read of both letter positions, a registered read of
// both cipher letters from the key square, and a step to present each of the
// two cipher letters in the output register; each output step waits while
// the output side stalls. The first letter of a pair carries last_of_pair
// low and the second carries it high.
module playfair_cipher_encryptor (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] opcode,
  input  logic [4:0] letter,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [4:0] cipher_letter,
  output logic       last_of_pair
);
  import pfe_pkg::*;

  cmd_t    cmd;
  status_t status;

  pfe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .opcode   (opcode),
    .status   (status),
    .cmd      (cmd)
  );

  pfe_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .letter        (letter),
    .cmd           (cmd),
    .status        (status),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .cipher_letter (cipher_letter),
    .last_of_pair  (last_of_pair)
  );

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Playfair encryptor. It builds one key square
// from key letter items and a finish item, then sends plaintext and end of
// message items with random gaps on both sides. A predictor in the bench
// keeps its own square and pairing state and queues the cipher letters
// each item should produce. Every output item is compared with the oldest
// one queued.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pfe_pkg::*;

  localparam int RANDOM_ITEMS = 1760;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 40;
  localparam int STALL_LIMIT  = 3000;
  localparam int MAX_GAP      = 13;

  typedef struct packed {
    logic [4:0] code;
    logic       last;
  } cipher_exp_t;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic [1:0] opcode    = OP_KEY;
  logic [4:0] letter    = 5'd0;
  logic       out_stall = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic [4:0] cipher_letter;
  logic       last_of_pair;

  cipher_exp_t cipher_due_q[$];

  logic [4:0] sq_cell[CELLS];
  logic       sq_used[LETTERS];
  logic [4:0] sq_pos[LETTERS];
  int         sq_fill;
  logic [4:0] open_letter;
  logic       open_valid;

  logic calm     = 1'b0;
  int   errors, items_sent, results_seen, idle_cycles, holds_done, holds_wanted;
  int   n_row, n_col, n_rect, n_filler, n_padded;

  playfair_cipher_encryptor DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .opcode       (opcode),
    .letter       (letter),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .cipher_letter(cipher_letter),
    .last_of_pair (last_of_pair)
  );

  always #2 clk = ~clk;

  task automatic report_mismatch(input string what);
    $display("tb_top: mismatch at %0t: %s", $realtime, what);
    errors++;
  endtask

  function automatic void place_letter(input logic [4:0] code);
    if (sq_fill < CELLS && !sq_used[code]) begin
      sq_used[code] = 1'b1;
      sq_cell[sq_fill] = code;
      sq_pos[code] = 5'(sq_fill);
      sq_fill++;
    end
  endfunction

  function automatic void encipher_pair(input logic [4:0] a, input logic [4:0] b);
    int ra, ca, rb, cb;
    logic [4:0] ea, eb;
    ra = sq_pos[a] / SIDE;
    ca = sq_pos[a] % SIDE;
    rb = sq_pos[b] / SIDE;
    cb = sq_pos[b] % SIDE;
    if (ra == rb) begin
      ea = sq_cell[ra * SIDE + (ca + 1) % SIDE];
      eb = sq_cell[rb * SIDE + (cb + 1) % SIDE];
      n_row++;
    end else if (ca == cb) begin
      ea = sq_cell[((ra + 1) % SIDE) * SIDE + ca];
      eb = sq_cell[((rb + 1) % SIDE) * SIDE + cb];
      n_col++;
    end else begin
      ea = sq_cell[ra * SIDE + cb];
      eb = sq_cell[rb * SIDE + ca];
      n_rect++;
    end
    cipher_due_q.push_back('{ea, 1'b0});
    cipher_due_q.push_back('{eb, 1'b1});
  endfunction

  function automatic void playfair_predict(input op_t op, input logic [4:0] raw);
    logic [4:0] code;
    int c;
    code = (raw == CODE_J) ? CODE_I : raw;
    case (op)
      OP_KEY: begin
        if (code < LETTERS) place_letter(code);
      end
      OP_FINISH: begin
        for (c = 0; c < LETTERS; c++) begin
          if (c != CODE_J) place_letter(5'(c));
        end
      end
      OP_PLAIN: begin
        if (code < LETTERS) begin
          if (!open_valid) begin
            open_letter = code;
            open_valid = 1'b1;
          end else if (open_letter == code) begin
            encipher_pair(open_letter, CODE_X);
            n_filler++;
          end else begin
            encipher_pair(open_letter, code);
            open_valid = 1'b0;
          end
        end
      end
      default: begin
        if (open_valid) begin
          encipher_pair(open_letter, CODE_X);
          open_valid = 1'b0;
          n_padded++;
        end
      end
    endcase
  endfunction

  task automatic send_item(input op_t op, input logic [4:0] ltr);
    int gap;
    gap = calm ? 0 : $urandom_range(MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode   <= op;
    letter   <= ltr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    playfair_predict(op, ltr);
    items_sent++;
  endtask

  // Output side: random hold-offs per item, plus one long hold on request.
  initial begin : result_sink
    int wait_cycles;
    while (rst) @(posedge clk);
    forever begin
      if (holds_done < holds_wanted) begin
        wait_cycles = HOLD_CYCLES;
        holds_done++;
      end else begin
        wait_cycles = calm ? 0 : $urandom_range(MAX_GAP);
      end
      if (wait_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin : result_check
    cipher_exp_t due;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (cipher_due_q.size() == 0) begin
        report_mismatch($sformatf("unexpected item %0d/%0b", cipher_letter, last_of_pair));
      end else begin
        due = cipher_due_q.pop_front();
        if (cipher_letter !== due.code)
          report_mismatch($sformatf("cipher_letter %0d, expected %0d",
                                    cipher_letter, due.code));
        if (last_of_pair !== due.last)
          report_mismatch($sformatf("last_of_pair %0b, expected %0b",
                                    last_of_pair, due.last));
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_top: no progress for %0d cycles", STALL_LIMIT);
      $display("tb_top: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Key with a folded J, a duplicate, a bad code and a plaintext letter
  // that opens a pair before the square is complete.
  task automatic test_key_square();
    send_item(OP_KEY, 5'd15);
    send_item(OP_KEY, 5'd11);
    send_item(OP_KEY, 5'd0);
    send_item(OP_KEY, 5'd24);
    send_item(OP_KEY, CODE_J);
    send_item(OP_KEY, CODE_I);
    send_item(OP_KEY, 5'd31);
    send_item(OP_PLAIN, 5'd7);
    send_item(OP_KEY, 5'd4);
    send_item(OP_KEY, CODE_X);
    send_item(OP_KEY, 5'd12);
    send_item(OP_FINISH, 5'($urandom_range(31)));
    send_item(OP_FINISH, 5'($urandom_range(31)));
    send_item(OP_KEY, 5'd16);
  endtask

  task automatic test_pairing();
    send_item(OP_PLAIN, 5'd4);
    send_item(OP_PLAIN, 5'd0);
    send_item(OP_PLAIN, 5'd0);
    send_item(OP_PLAIN, 5'd12);
    send_item(OP_PLAIN, 5'd11);
    send_item(OP_PLAIN, 5'd24);
    send_item(OP_PLAIN, CODE_X);
    send_item(OP_PLAIN, CODE_X);
    send_item(OP_END, 5'd31);
    send_item(OP_END, 5'd0);
    send_item(OP_PLAIN, 5'd27);
    send_item(OP_PLAIN, CODE_J);
    send_item(OP_PLAIN, CODE_I);
    send_item(OP_PLAIN, 5'd25);
  endtask

  task automatic test_random(input int count);
    int sent, r;
    op_t op;
    logic [4:0] ltr;
    sent = 0;
    while (sent < count) begin
      if (sent % 150 == 0) calm = ($urandom_range(3) == 0);
      r = $urandom_range(99);
      ltr = 5'($urandom_range(31));
      if (r < 60) begin
        op = OP_PLAIN;
        ltr = 5'($urandom_range(LETTERS - 1));
      end else if (r < 70) begin
        op = OP_PLAIN;
        ltr = open_valid ? open_letter : 5'($urandom_range(LETTERS - 1));
      end else if (r < 75) begin
        op = OP_PLAIN;
        ltr = CODE_X;
      end else if (r < 83) begin
        op = OP_END;
      end else if (r < 88) begin
        op = OP_PLAIN;
        ltr = 5'($urandom_range(31, LETTERS));
      end else if (r < 93) begin
        op = OP_KEY;
      end else begin
        op = OP_FINISH;
      end
      sent++;
      send_item(op, ltr);
    end
    calm = 1'b0;
  endtask

  // The sink holds off for a long stretch while items keep coming in.
  task automatic test_backpressure();
    int k;
    calm = 1'b1;
    holds_wanted++;
    for (k = 0; k < 60; k++) send_item(OP_PLAIN, 5'($urandom_range(LETTERS - 1)));
    calm = 1'b0;
  endtask

  initial begin : stimulus
    int k;
    for (k = 0; k < LETTERS; k++) sq_used[k] = 1'b0;
    sq_fill = 0;
    open_letter = 5'd0;
    open_valid = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_key_square();
    test_pairing();
    test_random(RANDOM_ITEMS / 2);
    test_backpressure();
    test_random(RANDOM_ITEMS - RANDOM_ITEMS / 2);
    in_valid <= 1'b0;
    while (cipher_due_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (cipher_due_q.size() != 0) report_mismatch("expected items never arrived");
    $display("tb_top: %0d items in, %0d cipher letters checked, %0d long holds",
             items_sent, results_seen, holds_done);
    $display("tb_top: pairs by row %0d, column %0d, rectangle %0d; X fillers %0d, pads %0d",
             n_row, n_col, n_rect, n_filler, n_padded);
    if (errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
